### src/pva_pkg.sv
// Shared types and codes of the polyphonic voice allocator.
`default_nettype none

package pva_pkg;

  // Command codes of an input word; the fourth code is ignored.
  typedef enum logic [1:0] {
    CMD_NOTE_ON    = 2'd0,
    CMD_NOTE_OFF   = 2'd1,
    CMD_VOICE_IDLE = 2'd2
  } cmd_e;

  // Action codes of a result word.
  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_TRIGGER     = 3'd1,
    ACT_STEAL       = 3'd2,
    ACT_RELEASED    = 3'd3,
    ACT_PEND_START  = 3'd4,
    ACT_DEACTIVATED = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_APPLY
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input word, restart the scan
    logic scan_rd;  // read the voice at the scan counter, advance it
    logic apply;    // update voice state and load the result word
  } pva_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // scan counter sits on the last voice
    logic out_free;   // result register can take a word this cycle
  } pva_stat_t;

endpackage

`default_nettype wire

### src/pva_ctrl.sv
// Controller state machine of the voice allocator.
`default_nettype none

module pva_ctrl
  import pva_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_stall_o,
  input  pva_stat_t  stat_i,
  output pva_ctrl_t  ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_NOTE_ON || in_cmd_i == CMD_NOTE_OFF) begin
            state_d = ST_SCAN;
          end else if (in_cmd_i == CMD_VOICE_IDLE) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_APPLY;
      ST_READ:  state_d = ST_APPLY;
      ST_APPLY: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        ctrl_o.load = in_valid_i;
      end
      ST_SCAN:  ctrl_o.scan_rd = 1'b1;
      ST_APPLY: ctrl_o.apply = stat_i.out_free;
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/pva_datapath.sv
// Datapath of the voice allocator: voice flags, voice memories, scan and result register.
`default_nettype none

module pva_datapath
  import pva_pkg::*;
#(
  parameter int VOICES     = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pva_ctrl_t  ctrl_i,
  output pva_stat_t  stat_o,
  input  logic [1:0] cmd_i,
  input  logic [6:0] note_i,
  input  logic [6:0] velocity_i,
  input  logic [2:0] idle_voice_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [2:0] voice_index_o,
  output logic [7:0] release_mask_o,
  output logic [6:0] start_note_o,
  output logic [6:0] start_velocity_o
);

  localparam int VW = $clog2(VOICES);

  typedef logic [VW-1:0] vidx_t;

  // Captured input word.
  logic [1:0] cmd_q;
  logic [6:0] note_q, vel_q;
  logic [2:0] iv_q;

  // Voice flags.
  logic [VOICES-1:0] active_q, active_d;
  logic [VOICES-1:0] rel_q, rel_d;
  logic [VOICES-1:0] pval_q, pval_d;

  // Voice memories, read data registered.
  logic [6:0]            vnote_mem [VOICES];
  logic [6:0]            pnote_mem [VOICES];
  logic [6:0]            pvel_mem  [VOICES];
  logic [STAMP_BITS-1:0] stamp_mem [VOICES];
  logic [6:0]            vnote_rd_q, pnote_rd_q, pvel_rd_q;
  logic [STAMP_BITS-1:0] stamp_rd_q;
  logic                  rd_vld_q;
  vidx_t                 rd_idx_q, rd_addr;

  // Scan state.
  vidx_t                 scan_cnt_q;
  logic                  free_found_q, rel_found_q, any_q;
  vidx_t                 free_idx_q, rel_idx_q, best_idx_q, first_idx_q;
  logic [STAMP_BITS-1:0] best_stamp_q;
  logic [VOICES-1:0]     relvec_q;

  logic [STAMP_BITS-1:0] stamp_cnt_q;

  // Write controls.
  logic       vnote_we, pend_we, stamp_we;
  vidx_t      tgt;
  logic [6:0] vnote_wd;

  // Result.
  logic       out_valid_q;
  logic [2:0] act_d, act_q;
  logic [2:0] vout_d, vout_q;
  logic [7:0] mask_d, mask_q;
  logic [6:0] snote_d, snote_q, svel_d, svel_q;

  vidx_t ivx, pick;
  logic  iv_in_range, on_match, pend_match;

  assign ivx         = VW'(iv_q);
  assign iv_in_range = (32'(iv_q) < VOICES);
  assign pick        = free_found_q ? free_idx_q : (rel_found_q ? rel_idx_q : best_idx_q);
  assign rd_addr     = ctrl_i.scan_rd ? scan_cnt_q : ivx;
  assign on_match    = active_q[rd_idx_q] && (vnote_rd_q == note_q);
  assign pend_match  = pval_q[rd_idx_q] && (pnote_rd_q == note_q);

  assign stat_o.scan_last = (scan_cnt_q == VW'(VOICES - 1));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // Capture the input word.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      note_q <= note_i;
      vel_q  <= velocity_i;
      iv_q   <= idle_voice_i;
    end
  end

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (vnote_we) begin
      vnote_mem[tgt] <= vnote_wd;
    end
    if (pend_we) begin
      pnote_mem[tgt] <= note_q;
      pvel_mem[tgt]  <= vel_q;
    end
    if (stamp_we) begin
      stamp_mem[tgt] <= stamp_cnt_q;
    end
    vnote_rd_q <= vnote_mem[rd_addr];
    pnote_rd_q <= pnote_mem[rd_addr];
    pvel_rd_q  <= pvel_mem[rd_addr];
    stamp_rd_q <= stamp_mem[rd_addr];
    rd_idx_q   <= rd_addr;
  end

  // Scan over the voices, one per cycle behind the memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q     <= 1'b0;
      scan_cnt_q   <= '0;
      free_found_q <= 1'b0;
      rel_found_q  <= 1'b0;
      any_q        <= 1'b0;
      free_idx_q   <= '0;
      rel_idx_q    <= '0;
      best_idx_q   <= '0;
      first_idx_q  <= '0;
      best_stamp_q <= '0;
      relvec_q     <= '0;
    end else begin
      rd_vld_q <= ctrl_i.scan_rd;
      if (ctrl_i.load) begin
        scan_cnt_q   <= '0;
        free_found_q <= 1'b0;
        rel_found_q  <= 1'b0;
        any_q        <= 1'b0;
        relvec_q     <= '0;
      end else if (ctrl_i.scan_rd) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (rd_vld_q) begin
        if (!active_q[rd_idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= rd_idx_q;
        end
        if (rel_q[rd_idx_q] && !rel_found_q) begin
          rel_found_q <= 1'b1;
          rel_idx_q   <= rd_idx_q;
        end
        // Strict compare keeps the lowest voice on equal stamps.
        if (rd_idx_q == '0 || stamp_rd_q < best_stamp_q) begin
          best_idx_q   <= rd_idx_q;
          best_stamp_q <= stamp_rd_q;
        end
        if (on_match) begin
          relvec_q[rd_idx_q] <= 1'b1;
          if (!any_q) begin
            first_idx_q <= rd_idx_q;
          end
          any_q <= 1'b1;
        end
      end
    end
  end

  // Flag updates, memory writes and the result word.
  always_comb begin
    active_d = active_q;
    rel_d    = rel_q;
    pval_d   = pval_q;
    vnote_we = 1'b0;
    pend_we  = 1'b0;
    stamp_we = 1'b0;
    tgt      = ivx;
    vnote_wd = note_q;
    act_d    = ACT_NONE;
    vout_d   = '0;
    mask_d   = '0;
    snote_d  = '0;
    svel_d   = '0;

    if (rd_vld_q && cmd_q == CMD_NOTE_OFF) begin
      if (on_match) begin
        rel_d[rd_idx_q] = 1'b1;
      end
      if (pend_match) begin
        pval_d[rd_idx_q] = 1'b0;
      end
    end

    if (ctrl_i.apply) begin
      unique case (cmd_q)
        CMD_NOTE_ON: begin
          tgt      = pick;
          stamp_we = 1'b1;
          vout_d   = 3'(pick);
          snote_d  = note_q;
          svel_d   = vel_q;
          if (active_q[pick]) begin
            // Busy voice: queue the note and push the voice into release.
            pend_we     = 1'b1;
            rel_d[pick] = 1'b1;
            pval_d[pick] = 1'b1;
            act_d       = ACT_STEAL;
          end else begin
            vnote_we       = 1'b1;
            active_d[pick] = 1'b1;
            rel_d[pick]    = 1'b0;
            pval_d[pick]   = 1'b0;
            act_d          = ACT_TRIGGER;
          end
        end
        CMD_NOTE_OFF: begin
          mask_d = 8'(relvec_q);
          if (any_q) begin
            act_d  = ACT_RELEASED;
            vout_d = 3'(first_idx_q);
          end
        end
        CMD_VOICE_IDLE: begin
          if (iv_in_range && active_q[ivx]) begin
            vout_d = iv_q;
            if (pval_q[ivx]) begin
              vnote_wd = pnote_rd_q;
              vnote_we = 1'b1;
              snote_d  = pnote_rd_q;
              svel_d   = pvel_rd_q;
              rel_d[ivx]  = 1'b0;
              pval_d[ivx] = 1'b0;
              act_d       = ACT_PEND_START;
            end else begin
              active_d[ivx] = 1'b0;
              rel_d[ivx]    = 1'b0;
              act_d         = ACT_DEACTIVATED;
            end
          end
        end
        default: begin
          act_d = ACT_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      rel_q       <= '0;
      pval_q      <= '0;
      stamp_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      rel_q    <= rel_d;
      pval_q   <= pval_d;
      // Hold the age counter at its top value.
      if (stamp_we && stamp_cnt_q != '1) begin
        stamp_cnt_q <= stamp_cnt_q + 1'b1;
      end
      if (ctrl_i.apply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      act_q   <= act_d;
      vout_q  <= vout_d;
      mask_q  <= mask_d;
      snote_q <= snote_d;
      svel_q  <= svel_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign action_o         = act_q;
  assign voice_index_o    = vout_q;
  assign release_mask_o   = mask_q;
  assign start_note_o     = snote_q;
  assign start_velocity_o = svel_q;

  a_rel_implies_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rel_q & ~active_q) == '0)
    else $error("releasing flag set on an inactive voice");

  a_pend_implies_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pval_q & ~active_q) == '0)
    else $error("pending note held by an inactive voice");

  a_apply_gives_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.apply |=> out_valid_q)
    else $error("update finished without a result word");

  a_scan_not_on_apply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.apply |-> !rd_vld_q)
    else $error("result word taken before the scan drained");

endmodule

`default_nettype wire

### src/polyphonic_voice_allocator_core.sv
// Top level of the polyphonic voice allocator.
`default_nettype none

// Polyphonic voice allocator over a pool of VOICES voices. Every input word
// (note on, note off, voice envelope idle) yields exactly one result word.
// A note on takes the lowest free voice and triggers it; with no free voice
// it takes the lowest releasing voice, otherwise the voice with the oldest
// age stamp, queues the note there as pending and puts that voice into
// release. A note off releases every active voice holding the note and drops
// matching pending notes. A voice idle word starts the voice's pending note
// or frees the voice; an idle word for a voice that is out of range or not
// active, and the unused command code, give action none. The age counter is
// STAMP_BITS wide and holds at its top value. Timing: note on and note off
// read the voice memories one voice per cycle through a single read port,
// and such a word passes through the scan, drain and apply states before the
// next accept; a voice idle word passes through the read and apply states,
// and the unused command goes straight to apply. The result sits in an output
// register, so a new word is accepted while the previous result still waits
// under stall; the block holds off the next update only until that register
// is free. There is no clearing pass after reset: voice flags reset at once,
// and the note, pending and stamp memories are used only for written voices.
module polyphonic_voice_allocator_core
  import pva_pkg::*;
#(
  parameter int VOICES     = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input words
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [6:0] note_i,
  input  logic [6:0] velocity_i,
  input  logic [2:0] idle_voice_i,
  // result words
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [2:0] voice_index_o,
  output logic [7:0] release_mask_o,
  output logic [6:0] start_note_o,
  output logic [6:0] start_velocity_o
);

  pva_ctrl_t ctrl;
  pva_stat_t stat;

  // Sequencer: accept, scan and drain the read pipe or read one voice, apply and emit.
  pva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (cmd_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Voice state, memories, scan accumulators and the result register.
  pva_datapath #(
    .VOICES     (VOICES),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .cmd_i            (cmd_i),
    .note_i           (note_i),
    .velocity_i       (velocity_i),
    .idle_voice_i     (idle_voice_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .voice_index_o    (voice_index_o),
    .release_mask_o   (release_mask_o),
    .start_note_o     (start_note_o),
    .start_velocity_o (start_velocity_o)
  );

endmodule

`default_nettype wire

### verif/polyphonic_voice_allocator_core_tb.sv
// Self-checking testbench for the polyphonic voice allocator core.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_core_tb;
  import pva_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int NUM_VOICES   = 8;
  localparam int STAMP_W      = 32;
  localparam int HOLD_CYCLES  = 200;     // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 30;      // quiet cycles after the last result
  localparam int CYCLE_LIMIT  = 400000;  // several times the slowest legal run

  localparam logic [STAMP_W-1:0] STAMP_TOP  = '1;
  localparam logic [1:0]         CMD_UNUSED = 2'd3;  // fourth code, ignored by the block

  // One expected result word.
  typedef struct {
    action_e    action;
    logic [2:0] voice;
    logic [7:0] mask;
    logic [6:0] note;
    logic [6:0] vel;
  } alloc_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] cmd_i;
  logic [6:0] note_i;
  logic [6:0] velocity_i;
  logic [2:0] idle_voice_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] action_o;
  logic [2:0] voice_index_o;
  logic [7:0] release_mask_o;
  logic [6:0] start_note_o;
  logic [6:0] start_velocity_o;

  // Voice pool as the testbench sees it; advanced once per accepted word.
  bit                 busy        [NUM_VOICES];
  bit                 in_release  [NUM_VOICES];
  logic [6:0]         held_note   [NUM_VOICES];
  bit                 queued      [NUM_VOICES];
  logic [6:0]         queued_note [NUM_VOICES];
  logic [6:0]         queued_vel  [NUM_VOICES];
  logic [STAMP_W-1:0] age_stamp   [NUM_VOICES];
  logic [STAMP_W-1:0] age_next;

  alloc_result_t expected_allocs[$];
  int            mismatch_count;
  int            cycle_count;

  // Sender burst control.
  bit            steady_send;
  int unsigned   burst_left;

  // Receiver stall control; the hold-off length is counted in the stall process.
  bit            hold_request;
  int unsigned   hold_left;
  int unsigned   rx_mode;
  int unsigned   rx_mode_left;
  int unsigned   rx_phase;

  polyphonic_voice_allocator_core #(
    .VOICES    (NUM_VOICES),
    .STAMP_BITS(STAMP_W)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .note_i          (note_i),
    .velocity_i      (velocity_i),
    .idle_voice_i    (idle_voice_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .voice_index_o   (voice_index_o),
    .release_mask_o  (release_mask_o),
    .start_note_o    (start_note_o),
    .start_velocity_o(start_velocity_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Allocation predictor
  // ---------------------------------------------------------------------------

  // Pick the target of a note on: lowest free voice, then lowest releasing
  // voice, then the oldest stamp with ties going to the lowest index.
  function automatic int choose_voice();
    int oldest;
    oldest = 0;
    for (int i = 0; i < NUM_VOICES; i++) if (!busy[i]) return i;
    for (int i = 0; i < NUM_VOICES; i++) if (in_release[i]) return i;
    for (int i = 1; i < NUM_VOICES; i++) if (age_stamp[i] < age_stamp[oldest]) oldest = i;
    return oldest;
  endfunction

  function automatic void start_voice(input int v, input logic [6:0] note);
    busy[v]       = 1'b1;
    in_release[v] = 1'b0;
    queued[v]     = 1'b0;
    held_note[v]  = note;
  endfunction

  // Advance the pool by one word and return the result it must produce.
  function automatic alloc_result_t predict_allocation(input logic [1:0] cmd,
                                                       input logic [6:0] note,
                                                       input logic [6:0] vel,
                                                       input logic [2:0] iv);
    alloc_result_t res;
    int            v;
    bit            hit;
    res = '{ACT_NONE, 3'd0, 8'd0, 7'd0, 7'd0};
    case (cmd)
      CMD_NOTE_ON: begin
        v = choose_voice();
        if (busy[v]) begin
          // Steal: queue the note and push the voice into release.
          queued[v]      = 1'b1;
          queued_note[v] = note;
          queued_vel[v]  = vel;
          in_release[v]  = 1'b1;
          res.action     = ACT_STEAL;
        end else begin
          start_voice(v, note);
          res.action = ACT_TRIGGER;
        end
        res.voice    = 3'(v);
        res.note     = note;
        res.vel      = vel;
        age_stamp[v] = age_next;
        if (age_next != STAMP_TOP) age_next++;
      end
      CMD_NOTE_OFF: begin
        hit = 1'b0;
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (busy[i] && held_note[i] == note) begin
            in_release[i] = 1'b1;
            res.mask[i]   = 1'b1;
            if (!hit) res.voice = 3'(i);
            hit = 1'b1;
          end
          // Drop matching queued notes even when nothing is released.
          if (queued[i] && queued_note[i] == note) queued[i] = 1'b0;
        end
        if (hit) res.action = ACT_RELEASED;
      end
      CMD_VOICE_IDLE: begin
        if (busy[iv]) begin
          res.voice = iv;
          if (queued[iv]) begin
            res.note   = queued_note[iv];
            res.vel    = queued_vel[iv];
            res.action = ACT_PEND_START;
            start_voice(iv, queued_note[iv]);
          end else begin
            busy[iv]       = 1'b0;
            in_release[iv] = 1'b0;
            res.action     = ACT_DEACTIVATED;
          end
        end
      end
      default: ;  // unused code: no state change
    endcase
    return res;
  endfunction

  function automatic int random_busy_voice();
    int list[$];
    for (int i = 0; i < NUM_VOICES; i++) if (busy[i]) list.push_back(i);
    if (list.size() == 0) return -1;
    return list[$urandom_range(list.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Sample each accepted result word at the rising edge and match it against
  // the oldest expectation.
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_allocs.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual action %0h",
                 $time, action_o);
        mismatch_count++;
      end else begin
        want = expected_allocs.pop_front();
        check_field("action",         want.action, action_o);
        check_field("voice_index",    want.voice,  voice_index_o);
        check_field("release_mask",   want.mask,   release_mask_o);
        check_field("start_note",     want.note,   start_note_o);
        check_field("start_velocity", want.vel,    start_velocity_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern
  // ---------------------------------------------------------------------------

  // Switch between free flow, light and heavy random stall and a fixed
  // two-in-five pattern; a requested hold-off overrides all of them.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(3);
        rx_mode_left = $urandom_range(80, 16);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(99) < 30);
        2:       out_stall_i <= ($urandom_range(99) < 70);
        default: out_stall_i <= (rx_phase % 5 < 2);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Drive one word at the falling edge, hold it until accepted, then predict
  // its result. Between bursts, drop valid for a random gap.
  task automatic offer_word(input logic [1:0] cmd, input logic [6:0] note,
                            input logic [6:0] vel, input logic [2:0] iv);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    note_i       <= note;
    velocity_i   <= vel;
    idle_voice_i <= iv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_allocs.push_back(predict_allocation(cmd, note, vel, iv));
    if (!steady_send) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(14, 1);
        if (gap != 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
        burst_left = $urandom_range(24, 1);
      end
    end
  endtask

  // Stop offering and hold until every expected result has arrived.
  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill the pool with field extremes and a duplicate note, then steal the
  // oldest voice and steal the same releasing voice a second time.
  task automatic test_allocation();
    offer_word(CMD_NOTE_ON, 7'd0,   7'd0,   3'd0);
    offer_word(CMD_NOTE_ON, 7'd127, 7'd127, 3'd7);
    offer_word(CMD_NOTE_ON, 7'd60,  7'h55,  3'd5);
    offer_word(CMD_NOTE_ON, 7'd60,  7'h2a,  3'd2);
    offer_word(CMD_NOTE_ON, 7'd61,  7'd100, 3'd0);
    offer_word(CMD_NOTE_ON, 7'd62,  7'd100, 3'd0);
    offer_word(CMD_NOTE_ON, 7'd63,  7'd100, 3'd0);
    offer_word(CMD_NOTE_ON, 7'd64,  7'd100, 3'd0);
    offer_word(CMD_NOTE_ON, 7'd70,  7'd1,   3'd0);
    offer_word(CMD_NOTE_ON, 7'd71,  7'd2,   3'd0);
  endtask

  // Release two voices at once, cancel a queued note with no voice match,
  // and send a note off that hits nothing.
  task automatic test_release();
    offer_word(CMD_NOTE_OFF, 7'd60, 7'd127, 3'd7);
    offer_word(CMD_NOTE_OFF, 7'd71, 7'd0,   3'd0);
    offer_word(CMD_NOTE_OFF, 7'd99, 7'd0,   3'd0);
  endtask

  // Free a voice, idle an inactive voice, reuse freed voices, steal a releasing
  // voice and start its queued note, send the unused code, then free voice 7.
  task automatic test_voice_idle();
    offer_word(CMD_VOICE_IDLE, 7'd0,   7'd0,   3'd0);
    offer_word(CMD_VOICE_IDLE, 7'd127, 7'd127, 3'd0);
    offer_word(CMD_VOICE_IDLE, 7'd0,   7'd0,   3'd2);
    offer_word(CMD_NOTE_ON,    7'd72,  7'd3,   3'd0);
    offer_word(CMD_NOTE_ON,    7'd73,  7'd4,   3'd0);
    offer_word(CMD_NOTE_ON,    7'd74,  7'd5,   3'd0);
    offer_word(CMD_VOICE_IDLE, 7'd0,   7'd0,   3'd3);
    offer_word(CMD_UNUSED,     7'd127, 7'd127, 3'd7);
    offer_word(CMD_VOICE_IDLE, 7'd0,   7'd0,   3'd7);
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // output register fills and the block stalls its input.
  task automatic test_backpressure();
    wait_all_results();
    hold_request = 1'b1;
    steady_send  = 1'b1;
    for (int k = 0; k < 10; k++) begin
      if (k % 3 == 2) offer_word(CMD_VOICE_IDLE, 7'($urandom_range(127)), 7'(k), 3'(k));
      else offer_word(CMD_NOTE_ON, 7'(40 + k), 7'(k * 12), 3'(k));
    end
    steady_send = 1'b0;
    wait_all_results();
  endtask

  // Mostly well-formed traffic: notes drawn from a small pool so that note
  // offs match, note offs aimed at sounding voices, idle words aimed at busy
  // voices; the rest is random noise and the unused code.
  task automatic test_random_traffic(input int unsigned count, input int unsigned on_pct);
    logic [6:0]  note_pool[8];
    logic [1:0]  cmd;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [2:0]  iv;
    int unsigned r;
    int          bv;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) foreach (note_pool[p]) note_pool[p] = 7'($urandom_range(127));
      note = 7'($urandom_range(127));
      vel  = 7'($urandom_range(127));
      iv   = 3'($urandom_range(7));
      r    = $urandom_range(99);
      if (r < on_pct) begin
        cmd = CMD_NOTE_ON;
        if ($urandom_range(4) != 0) note = note_pool[$urandom_range(7)];
      end else if (r < on_pct + 22) begin
        cmd = CMD_NOTE_OFF;
        bv  = random_busy_voice();
        if (bv >= 0 && $urandom_range(9) < 6) note = held_note[bv];
        else if ($urandom_range(1) == 1) note = note_pool[$urandom_range(7)];
      end else if (r < 97) begin
        cmd = CMD_VOICE_IDLE;
        bv  = random_busy_voice();
        if (bv >= 0 && $urandom_range(3) != 0) iv = 3'(bv);
      end else begin
        cmd = CMD_UNUSED;
      end
      offer_word(cmd, note, vel, iv);
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_NOTE_ON;
    note_i         = '0;
    velocity_i     = '0;
    idle_voice_i   = '0;
    out_stall_i    = 1'b0;
    age_next       = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    steady_send    = 1'b0;
    burst_left     = 0;
    hold_request   = 1'b0;
    hold_left      = 0;
    rx_mode        = 0;
    rx_mode_left   = 0;
    rx_phase       = 0;
    foreach (age_stamp[i]) age_stamp[i] = '0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_allocation();
    test_release();
    test_voice_idle();
    test_backpressure();
    test_random_traffic(240, 40);
    wait_all_results();  // sender pause with the pool in mid-state
    test_random_traffic(240, 55);
    test_random_traffic(240, 30);
    wait_all_results();
    test_random_traffic(230, 45);

    // Drain, then watch for stray words before deciding.
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### polyphonic_voice_allocator_core.f
src/pva_pkg.sv
src/pva_ctrl.sv
src/pva_datapath.sv
src/polyphonic_voice_allocator_core.sv
verif/polyphonic_voice_allocator_core_tb.sv
